// ----- rtl/ps2sc_pkg.sv -----
// ----------------------------------------------------------------------------
// PS/2 scan-code queue package
// Shared types, constants and byte-sequence functions for the PS/2 set-2
// scan-code queue and strobe unit.
// ----------------------------------------------------------------------------
package ps2sc_pkg;

   // Queue geometry
   localparam int QUEUE_DEPTH = 16;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Field widths
   localparam int TIMER_W   = 24;
   localparam int ELAPSED_W = 10;
   localparam int CODE_W    = 16;
   localparam int LEN_W     = 4;
   localparam int IDX_W     = 3;
   localparam int DROP_W    = 4;
   localparam int FILL_W    = 5;
   localparam int CSR_IDX_W = 2;

   localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

   // Configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_ACTIVE_TIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_TIME    = 2'd1;
   localparam logic [TIMER_W-1:0]   ACTIVE_TIME_RST = 24'd197;
   localparam logic [TIMER_W-1:0]   GAP_TIME_RST    = 24'd39000;

   // Special key selectors; the spare code acts as a normal key
   localparam logic [1:0] SK_NORMAL = 2'd0;
   localparam logic [1:0] SK_PAUSE  = 2'd1;
   localparam logic [1:0] SK_PRTSC  = 2'd2;

   // Scan-code bytes
   localparam logic [7:0] BYTE_E0 = 8'hE0;
   localparam logic [7:0] BYTE_F0 = 8'hF0;

   localparam logic [7:0] PAUSE_SEQ [8] = '{8'hE1, 8'h14, 8'h77, 8'hE1,
                                            8'hF0, 8'h14, 8'hE0, 8'h77};
   localparam logic [7:0] PRTSC_SEQ [4] = '{8'hE0, 8'h12, 8'hE0, 8'h7C};

   typedef enum logic [1:0] {
      OP_TICK    = 2'd0,
      OP_PRESS   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_READ    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_ACTIVE = 2'd1,
      PH_GAP    = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_PUSH     = 3'd1,
      ST_TICK_ADD = 3'd2,
      ST_TICK_CMP = 3'd3,
      ST_FINISH   = 3'd4
   } seq_state_type;

   // Number of make bytes of a key
   function automatic logic [LEN_W-1:0] make_len(logic [CODE_W-1:0] code,
                                                 logic [1:0] special);
      logic [LEN_W-1:0] len;
      case (special)
         SK_PAUSE: len = 4'd8;
         SK_PRTSC: len = 4'd4;
         default:  len = (code[15:8] != 8'h00) ? 4'd2 : 4'd1;
      endcase
      return len;
   endfunction

   // Make byte at a position of the key's sequence
   function automatic logic [7:0] make_byte(logic [CODE_W-1:0] code,
                                            logic [1:0] special,
                                            logic [IDX_W-1:0] idx);
      logic [7:0] b;
      case (special)
         SK_PAUSE: b = PAUSE_SEQ[idx];
         SK_PRTSC: b = PRTSC_SEQ[idx[1:0]];
         default: begin
            if (code[15:8] != 8'h00 && idx == 3'd0) begin
               b = code[15:8];
            end else begin
               b = code[7:0];
            end
         end
      endcase
      return b;
   endfunction

   // Number of bytes a press or release request queues
   function automatic logic [LEN_W-1:0] event_len(logic [CODE_W-1:0] code,
                                                  logic [1:0] special,
                                                  logic release_evt);
      logic [LEN_W-1:0] len;
      len = make_len(code, special);
      if (release_evt) begin
         len = (special == SK_PAUSE) ? 4'd0 : len + 4'd1;
      end
      return len;
   endfunction

   // Byte at a position of the press or release sequence; a release puts F0
   // after a leading E0 prefix, else in front of all make bytes
   function automatic logic [7:0] event_byte(logic [CODE_W-1:0] code,
                                             logic [1:0] special,
                                             logic release_evt,
                                             logic [IDX_W-1:0] idx);
      logic [7:0]       b;
      logic [IDX_W-1:0] f0_pos;
      f0_pos = (make_byte(code, special, 3'd0) == BYTE_E0) ? 3'd1 : 3'd0;
      if (!release_evt) begin
         b = make_byte(code, special, idx);
      end else if (idx == f0_pos) begin
         b = BYTE_F0;
      end else if (idx < f0_pos) begin
         b = make_byte(code, special, idx);
      end else begin
         b = make_byte(code, special, idx - 3'd1);
      end
      return b;
   endfunction

endpackage

// ----- rtl/ps2_scan_code_queue_and_strobe_unit.sv -----
// ----------------------------------------------------------------------------
// PS/2 scan-code queue and strobe unit
// Queues set-2 make and break bytes for key events and strobes them out one
// at a time under a tick-driven idle / active / gap machine.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request: tick, key press, key release or data read.
//   rsp_* returns one response per request: pin level, data register, queue
//   fill and the number of bytes of that request dropped on a full queue.
//   csr_* writes active_time (index 0) or gap_time (index 1); other indexes
//   are ignored. Write only while no request is in flight.
// Timing:
//   A request is taken in the idle cycle and worked on by a small sequencer.
//   A press or release writes one queue byte per cycle (up to eight); a tick
//   uses one shared 25-bit adder that first adds the elapsed time and then
//   compares the timer against the phase threshold. req_tready is low until
//   the sequencer is back in idle.
//   The response sits in an output register; the next request is taken
//   while it waits, and the sequencer holds in its last step if the receiver
//   is still stalled when the next response is ready.
// Reset: queue empty, phase idle, timer and data register zero, pin high,
//   registers at 197 and 39000. The queue memory itself is not cleared.
// ----------------------------------------------------------------------------
module ps2_scan_code_queue_and_strobe_unit (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // scan_code[15:0], elapsed[25:16], zero fill
   input  logic [3:0]  req_tuser,   // op[1:0], special_key[3:2]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // pin_level[0], read_data[8:1],
                                    // queue_fill[13:9], dropped_count[17:14]
   // configuration write channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [23:0] csr_data
);

   localparam int QPTR_W  = ps2sc_pkg::QPTR_W;
   localparam int QCNT_W  = ps2sc_pkg::QCNT_W;
   localparam int TIMER_W = ps2sc_pkg::TIMER_W;
   localparam int IDX_W   = ps2sc_pkg::IDX_W;
   localparam int LEN_W   = ps2sc_pkg::LEN_W;
   localparam int DROP_W  = ps2sc_pkg::DROP_W;
   localparam int FILL_W  = ps2sc_pkg::FILL_W;

   // Sequencer and control state
   ps2sc_pkg::seq_state_type state_ff, state_in;
   ps2sc_pkg::phase_type     phase_ff, phase_in;
   logic [QPTR_W-1:0]        head_ff, head_in;
   logic [QPTR_W-1:0]        tail_ff, tail_in;
   logic [QCNT_W-1:0]        count_ff, count_in;
   logic [TIMER_W-1:0]       timer_ff, timer_in;
   logic                     strobe_ff, strobe_in;
   logic [7:0]               data_reg_ff;
   logic [TIMER_W-1:0]       active_time_ff, active_time_in;
   logic [TIMER_W-1:0]       gap_time_ff, gap_time_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // Latched request and work registers
   ps2sc_pkg::op_type                  op_ff, op_in;
   logic [ps2sc_pkg::CODE_W-1:0]       code_ff, code_in;
   logic [1:0]                         special_ff, special_in;
   logic [ps2sc_pkg::ELAPSED_W-1:0]    elapsed_ff, elapsed_in;
   logic [LEN_W-1:0]                   len_ff, len_in;
   logic [IDX_W-1:0]                   idx_ff, idx_in;
   logic [DROP_W-1:0]                  drop_ff, drop_in;

   // Response register
   logic                               rsp_pin_ff, rsp_pin_in;
   logic [7:0]                         rsp_data_ff, rsp_data_in;
   logic [QCNT_W-1:0]                  rsp_fill_ff, rsp_fill_in;
   logic [DROP_W-1:0]                  rsp_drop_ff, rsp_drop_in;

   // Queue memory
   logic [7:0]                         queue_mem [ps2sc_pkg::QUEUE_DEPTH];
   logic                               wr_en;
   logic [7:0]                         wr_byte;
   logic                               pop_en;

   // Shared timer adder
   logic [TIMER_W-1:0]                 alu_b;
   logic                               alu_cin;
   logic [TIMER_W:0]                   alu_sum;

   logic                               req_fire;
   logic                               rsp_free;
   logic                               queue_full;
   logic [LEN_W-1:0]                   accept_len;
   logic [QCNT_W+FILL_W-1:0]           fill_wide;

   assign req_tready = (state_ff == ps2sc_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign queue_full = (count_ff == QCNT_W'(ps2sc_pkg::QUEUE_DEPTH));
   assign csr_ready  = 1'b1;

   assign accept_len = ps2sc_pkg::event_len(req_tdata[15:0], req_tuser[3:2],
                                             req_tuser[1:0] == ps2sc_pkg::OP_RELEASE);

   // Add elapsed time in the add step, subtract the threshold in the compare step
   always_comb begin
      if (state_ff == ps2sc_pkg::ST_TICK_ADD) begin
         alu_b   = TIMER_W'(elapsed_ff);
         alu_cin = 1'b0;
      end else begin
         alu_b   = (phase_ff == ps2sc_pkg::PH_GAP) ? ~gap_time_ff : ~active_time_ff;
         alu_cin = 1'b1;
      end
      alu_sum = {1'b0, timer_ff} + {1'b0, alu_b} + (TIMER_W+1)'(alu_cin);
   end

   // Sequencer next state and outputs
   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      head_in        = head_ff;
      tail_in        = tail_ff;
      count_in       = count_ff;
      timer_in       = timer_ff;
      strobe_in      = strobe_ff;
      active_time_in = active_time_ff;
      gap_time_in    = gap_time_ff;
      op_in          = op_ff;
      code_in        = code_ff;
      special_in     = special_ff;
      elapsed_in     = elapsed_ff;
      len_in         = len_ff;
      idx_in         = idx_ff;
      drop_in        = drop_ff;
      rsp_pin_in     = rsp_pin_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_fill_in    = rsp_fill_ff;
      rsp_drop_in    = rsp_drop_ff;
      rsp_valid_in   = rsp_tready ? 1'b0 : rsp_valid_ff;
      wr_en          = 1'b0;
      wr_byte        = ps2sc_pkg::event_byte(code_ff, special_ff,
                                             op_ff == ps2sc_pkg::OP_RELEASE, idx_ff);
      pop_en         = 1'b0;

      // Take configuration writes
      if (csr_valid && csr_ready) begin
         case (csr_index)
            ps2sc_pkg::CSR_ACTIVE_TIME: active_time_in = csr_data;
            ps2sc_pkg::CSR_GAP_TIME:    gap_time_in    = csr_data;
            default: ;
         endcase
      end

      case (state_ff)
         ps2sc_pkg::ST_IDLE: begin
            if (req_fire) begin
               op_in      = ps2sc_pkg::op_type'(req_tuser[1:0]);
               code_in    = req_tdata[15:0];
               special_in = req_tuser[3:2];
               elapsed_in = req_tdata[25:16];
               len_in     = accept_len;
               idx_in     = '0;
               drop_in    = '0;
               case (ps2sc_pkg::op_type'(req_tuser[1:0]))
                  ps2sc_pkg::OP_TICK: state_in = ps2sc_pkg::ST_TICK_ADD;
                  ps2sc_pkg::OP_PRESS,
                  ps2sc_pkg::OP_RELEASE: begin
                     state_in = (accept_len == '0) ? ps2sc_pkg::ST_FINISH
                                                   : ps2sc_pkg::ST_PUSH;
                  end
                  default: state_in = ps2sc_pkg::ST_FINISH;
               endcase
            end
         end

         // Write one byte per cycle, drop it on a full queue
         ps2sc_pkg::ST_PUSH: begin
            if (queue_full) begin
               drop_in = drop_ff + DROP_W'(1);
            end else begin
               wr_en    = 1'b1;
               tail_in  = (tail_ff == QPTR_W'(ps2sc_pkg::QUEUE_DEPTH - 1))
                          ? '0 : tail_ff + QPTR_W'(1);
               count_in = count_ff + QCNT_W'(1);
            end
            idx_in = idx_ff + IDX_W'(1);
            if (({1'b0, idx_ff} + LEN_W'(1)) == len_ff) begin
               state_in = ps2sc_pkg::ST_FINISH;
            end
         end

         // Advance the timer with saturation
         ps2sc_pkg::ST_TICK_ADD: begin
            timer_in = alu_sum[TIMER_W] ? ps2sc_pkg::TIMER_MAX : alu_sum[TIMER_W-1:0];
            state_in = ps2sc_pkg::ST_TICK_CMP;
         end

         // Step the strobe phase; the adder carry means timer >= threshold
         ps2sc_pkg::ST_TICK_CMP: begin
            case (phase_ff)
               ps2sc_pkg::PH_ACTIVE: begin
                  if (alu_sum[TIMER_W]) begin
                     strobe_in = 1'b1;
                     timer_in  = '0;
                     phase_in  = ps2sc_pkg::PH_GAP;
                  end
               end
               ps2sc_pkg::PH_GAP: begin
                  if (alu_sum[TIMER_W]) begin
                     strobe_in = 1'b1;
                     timer_in  = '0;
                     phase_in  = ps2sc_pkg::PH_IDLE;
                  end
               end
               default: begin
                  phase_in = ps2sc_pkg::PH_IDLE;
                  if (count_ff != '0) begin
                     pop_en    = 1'b1;
                     head_in   = (head_ff == QPTR_W'(ps2sc_pkg::QUEUE_DEPTH - 1))
                                 ? '0 : head_ff + QPTR_W'(1);
                     count_in  = count_ff - QCNT_W'(1);
                     strobe_in = 1'b0;
                     timer_in  = '0;
                     phase_in  = ps2sc_pkg::PH_ACTIVE;
                  end
               end
            endcase
            state_in = ps2sc_pkg::ST_FINISH;
         end

         // Load the response once the output register is free
         ps2sc_pkg::ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_pin_in   = strobe_ff;
               rsp_data_in  = data_reg_ff;
               rsp_fill_in  = count_ff;
               rsp_drop_in  = drop_ff;
               state_in     = ps2sc_pkg::ST_IDLE;
            end
         end

         default: state_in = ps2sc_pkg::ST_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ps2sc_pkg::ST_IDLE;
         phase_ff       <= ps2sc_pkg::PH_IDLE;
         head_ff        <= '0;
         tail_ff        <= '0;
         count_ff       <= '0;
         timer_ff       <= '0;
         strobe_ff      <= 1'b1;
         active_time_ff <= ps2sc_pkg::ACTIVE_TIME_RST;
         gap_time_ff    <= ps2sc_pkg::GAP_TIME_RST;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         phase_ff       <= phase_in;
         head_ff        <= head_in;
         tail_ff        <= tail_in;
         count_ff       <= count_in;
         timer_ff       <= timer_in;
         strobe_ff      <= strobe_in;
         active_time_ff <= active_time_in;
         gap_time_ff    <= gap_time_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      code_ff     <= code_in;
      special_ff  <= special_in;
      elapsed_ff  <= elapsed_in;
      len_ff      <= len_in;
      idx_ff      <= idx_in;
      drop_ff     <= drop_in;
      rsp_pin_ff  <= rsp_pin_in;
      rsp_data_ff <= rsp_data_in;
      rsp_fill_ff <= rsp_fill_in;
      rsp_drop_ff <= rsp_drop_in;
   end

   // Data register holds the last popped byte
   always_ff @(posedge clock) begin
      if (reset) begin
         data_reg_ff <= '0;
      end else if (pop_en) begin
         data_reg_ff <= queue_mem[head_ff];
      end
   end

   // Queue memory write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         queue_mem[tail_ff] <= wr_byte;
      end
   end

   // Pack the response
   assign fill_wide  = {{FILL_W{1'b0}}, rsp_fill_ff};
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_drop_ff, fill_wide[FILL_W-1:0], rsp_data_ff, rsp_pin_ff};

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(ps2sc_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");

   a_empty_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> head_ff == tail_ff)
      else $error("empty queue with head and tail apart");

   a_strobe_phase: assert property (@(posedge clock) disable iff (reset)
      strobe_ff == (phase_ff != ps2sc_pkg::PH_ACTIVE))
      else $error("pin level out of step with phase");

   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_drop_ff != '0 |-> rsp_fill_ff == QCNT_W'(ps2sc_pkg::QUEUE_DEPTH))
      else $error("bytes dropped while queue had room");

endmodule

// ----- bench/ps2_scan_code_queue_and_strobe_unit_tb.sv -----
// ----------------------------------------------------------------------------
// PS/2 scan-code queue and strobe unit testbench
// Drives tick, press, release and read requests through the request stream,
// predicts every response with a cycle-free model of the byte queue and the
// idle / active / gap strobe machine, and compares each response field by
// field. A directed table opens the run; random phases with different
// strobe timings, sender bursts and receiver stalls follow, and a short run
// under the largest active time closes it.
// ----------------------------------------------------------------------------
module ps2_scan_code_queue_and_strobe_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HALF_PERIOD    = 4;
   localparam int RESET_CYCLES   = 9;
   localparam int SETTLE_CYCLES  = 12;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int SOAK_TICKS     = 40;
   localparam int MAX_SHOWN      = 10;
   localparam int CYCLE_LIMIT    = 2_000_000;

   // Spare selector (taken as a normal key) and register indexes the block ignores
   localparam logic [1:0]                     SK_SPARE     = 2'd3;
   localparam logic [ps2sc_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [ps2sc_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef struct packed {
      logic [ps2sc_pkg::DROP_W-1:0] dropped_count;
      logic [ps2sc_pkg::FILL_W-1:0] queue_fill;
      logic [7:0]                   read_data;
      logic                         pin_level;
   } status_type;

   typedef struct {
      ps2sc_pkg::op_type               op;
      logic [ps2sc_pkg::CODE_W-1:0]    code;
      logic [1:0]                      sk;
      logic [ps2sc_pkg::ELAPSED_W-1:0] el;
      bit                              typed;
      status_type                      want;
   } stim_row_type;

   typedef struct {
      logic [ps2sc_pkg::TIMER_W-1:0] act;
      logic [ps2sc_pkg::TIMER_W-1:0] gp;
      int                            span;
      int                            items;
      int                            tick_pct;
      int                            gap_max;
      bit                            hold;
      bit                            drain;
      bit                            spare;
      logic [1:0]                    spare_idx;
   } plan_row_type;

   localparam status_type UNTYPED = '0;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // scan_code[15:0], elapsed[25:16], zero fill
   logic [3:0]  req_tuser  = '0;   // op[1:0], special_key[3:2]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;         // pin_level[0], read_data[8:1],
                                   // queue_fill[13:9], dropped_count[17:14]
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index  = '0;
   logic [23:0] csr_data   = '0;

   ps2_scan_code_queue_and_strobe_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Shadow of the block: byte queue, strobe machine and timing registers
   logic [7:0]                    key_fifo [ps2sc_pkg::QUEUE_DEPTH];
   int                            fifo_rd, fifo_wr, fifo_fill;
   ps2sc_pkg::phase_type          link_state;
   logic [ps2sc_pkg::TIMER_W-1:0] strobe_timer;
   logic [7:0]                    data_latch;
   logic                          pin_out;
   logic [ps2sc_pkg::TIMER_W-1:0] cfg_active, cfg_gap;

   status_type scan_status_due [$];
   int      fault_count   = 0;
   int      cycle_count   = 0;
   int      burst_left    = 4;
   int      sender_gap_max = 3;
   int      holdoff_asks  = 0;
   int      holdoff_served = 0;
   int      holdoff_left  = 0;
   logic [1:0] rx_mode    = 2'd0;
   logic [4:0] rx_pattern = 5'b10110;

   function automatic status_type status_is(logic pin, logic [7:0] data, logic [4:0] fill,
                                            logic [3:0] drop);
      status_type s;
      s.pin_level     = pin;
      s.read_data     = data;
      s.queue_fill    = fill;
      s.dropped_count = drop;
      return s;
   endfunction

   function automatic void note_fault(string what);
      fault_count++;
      if (fault_count <= MAX_SHOWN) $display("%0t: %s", $time, what);
   endfunction

   // Append one byte to the shadow queue; report 1 when it is dropped
   function automatic bit push_key_byte(logic [7:0] b);
      if (fifo_fill >= ps2sc_pkg::QUEUE_DEPTH) return 1'b1;
      key_fifo[fifo_wr] = b;
      fifo_wr = (fifo_wr + 1) % ps2sc_pkg::QUEUE_DEPTH;
      fifo_fill++;
      return 1'b0;
   endfunction

   // Advance the shadow by one request and return the status it reports
   function automatic status_type next_scan_status(ps2sc_pkg::op_type op,
                                                   logic [ps2sc_pkg::CODE_W-1:0] code,
                                                   logic [1:0] sk,
                                                   logic [ps2sc_pkg::ELAPSED_W-1:0] el);
      logic [7:0]  seq [8];
      int          n;
      int          first;
      int          i;
      logic [3:0]  lost;
      logic [24:0] sum;
      status_type  r;
      lost = '0;
      // make bytes of the key; the spare selector acts as a normal code
      if (sk == ps2sc_pkg::SK_PAUSE) begin
         seq = '{8'hE1, 8'h14, 8'h77, 8'hE1, 8'hF0, 8'h14, 8'hE0, 8'h77};
         n = 8;
      end else if (sk == ps2sc_pkg::SK_PRTSC) begin
         seq[0] = ps2sc_pkg::BYTE_E0;
         seq[1] = 8'h12;
         seq[2] = ps2sc_pkg::BYTE_E0;
         seq[3] = 8'h7C;
         n = 4;
      end else if (code[15:8] != 8'h00) begin
         seq[0] = code[15:8];
         seq[1] = code[7:0];
         n = 2;
      end else begin
         seq[0] = code[7:0];
         n = 1;
      end
      case (op)
         ps2sc_pkg::OP_TICK: begin
            // saturate the timer, then step the strobe machine
            sum = {1'b0, strobe_timer} + 25'(el);
            strobe_timer = (sum > 25'(ps2sc_pkg::TIMER_MAX)) ? ps2sc_pkg::TIMER_MAX
                                                              : sum[23:0];
            case (link_state)
               ps2sc_pkg::PH_ACTIVE: begin
                  if (strobe_timer >= cfg_active) begin
                     pin_out = 1'b1;
                     strobe_timer = '0;
                     link_state = ps2sc_pkg::PH_GAP;
                  end
               end
               ps2sc_pkg::PH_GAP: begin
                  if (strobe_timer >= cfg_gap) begin
                     pin_out = 1'b1;
                     strobe_timer = '0;
                     link_state = ps2sc_pkg::PH_IDLE;
                  end
               end
               default: begin
                  link_state = ps2sc_pkg::PH_IDLE;
                  if (fifo_fill > 0) begin
                     data_latch = key_fifo[fifo_rd];
                     fifo_rd = (fifo_rd + 1) % ps2sc_pkg::QUEUE_DEPTH;
                     fifo_fill--;
                     pin_out = 1'b0;
                     strobe_timer = '0;
                     link_state = ps2sc_pkg::PH_ACTIVE;
                  end
               end
            endcase
         end
         ps2sc_pkg::OP_PRESS: begin
            for (i = 0; i < n; i++) lost += push_key_byte(seq[i]);
         end
         ps2sc_pkg::OP_RELEASE: begin
            // break code: E0 kept in front, then F0, then the rest; Pause has none
            if (sk != ps2sc_pkg::SK_PAUSE) begin
               first = 0;
               if (seq[0] == ps2sc_pkg::BYTE_E0) begin
                  lost += push_key_byte(ps2sc_pkg::BYTE_E0);
                  first = 1;
               end
               lost += push_key_byte(ps2sc_pkg::BYTE_F0);
               for (i = first; i < n; i++) lost += push_key_byte(seq[i]);
            end
         end
         default: ;
      endcase
      r.pin_level     = pin_out;
      r.read_data     = data_latch;
      r.queue_fill    = 5'(fifo_fill);
      r.dropped_count = lost;
      return r;
   endfunction

   // Offer one request, predict its status on acceptance, then idle between bursts
   task automatic send_request(ps2sc_pkg::op_type op, logic [ps2sc_pkg::CODE_W-1:0] code,
                               logic [1:0] sk, logic [ps2sc_pkg::ELAPSED_W-1:0] el,
                               bit typed, status_type typed_want);
      status_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= {sk, op};
      req_tdata  <= {6'd0, el, code};
      do @(posedge clock); while (!req_tready);
      predicted = next_scan_status(op, code, sk, el);
      scan_status_due.push_back(typed ? typed_want : predicted);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(24, 1);
         if (sender_gap_max > 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(sender_gap_max, 1)) @(posedge clock);
         end
      end
   endtask

   // Stop offering and hold until every pending response has come back
   task automatic quiesce();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (scan_status_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [ps2sc_pkg::CSR_IDX_W-1:0] idx,
                            logic [ps2sc_pkg::TIMER_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == ps2sc_pkg::CSR_ACTIVE_TIME) cfg_active = value;
      else if (idx == ps2sc_pkg::CSR_GAP_TIME) cfg_gap = value;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Receiver: long hold-off on request, else a stall mode that changes now and then
   always @(posedge clock) begin
      if (holdoff_left > 0) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_served != holdoff_asks) begin
         rsp_tready     <= 1'b0;
         holdoff_served <= holdoff_served + 1;
         holdoff_left   <= HOLDOFF_CYCLES;
      end else begin
         if ($urandom_range(99) == 0) rx_mode <= 2'($urandom_range(3));
         rx_pattern <= {rx_pattern[0], rx_pattern[4:1]};
         case (rx_mode)
            2'd0:    rsp_tready <= 1'b1;
            2'd1:    rsp_tready <= 1'($urandom_range(1));
            2'd2:    rsp_tready <= rx_pattern[0];
            default: rsp_tready <= ($urandom_range(7) != 0);
         endcase
      end
   end

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin : rsp_check
      status_type got;
      status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = status_type'(rsp_tdata[17:0]);
         if (scan_status_due.size() == 0) begin
            note_fault($sformatf("response with none pending: %h", rsp_tdata));
         end else begin
            want = scan_status_due.pop_front();
            if (got.pin_level !== want.pin_level || got.read_data !== want.read_data ||
                got.queue_fill !== want.queue_fill ||
                got.dropped_count !== want.dropped_count) begin
               note_fault($sformatf({"mismatch: expected pin %0d data %02h fill %0d drop %0d,",
                                     " got pin %0d data %02h fill %0d drop %0d"},
                                    want.pin_level, want.read_data, want.queue_fill,
                                    want.dropped_count, got.pin_level, got.read_data,
                                    got.queue_fill, got.dropped_count));
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("ps2_scan_code_queue_and_strobe_unit_tb: errors");
         $finish;
      end
   end

   initial begin : stimulus
      stim_row_type                    stim_rows [20];
      plan_row_type                    plan [7];
      ps2sc_pkg::op_type               op;
      logic [ps2sc_pkg::CODE_W-1:0]    code;
      logic [1:0]                      sk;
      logic [ps2sc_pkg::ELAPSED_W-1:0] el;
      logic [ps2sc_pkg::TIMER_W-1:0]   act, gp;
      int                              p, n, roll;

      // expected columns: pin, data, fill, drop
      stim_rows = '{
         '{ps2sc_pkg::OP_READ,    16'h0000, ps2sc_pkg::SK_NORMAL, 10'd0,   1'b1,
           status_is(1'b1, 8'h00, 5'd0, 4'd0)},
         '{ps2sc_pkg::OP_TICK,    16'h0000, ps2sc_pkg::SK_NORMAL, 10'd0,   1'b1,
           status_is(1'b1, 8'h00, 5'd0, 4'd0)},
         '{ps2sc_pkg::OP_PRESS,   16'h001C, ps2sc_pkg::SK_NORMAL, 10'd0,   1'b1,
           status_is(1'b1, 8'h00, 5'd1, 4'd0)},
         '{ps2sc_pkg::OP_TICK,    16'h0000, ps2sc_pkg::SK_NORMAL, 10'd0,   1'b1,
           status_is(1'b0, 8'h1C, 5'd0, 4'd0)},
         '{ps2sc_pkg::OP_TICK,    16'h0000, ps2sc_pkg::SK_NORMAL, 10'h3FF, 1'b1,
           status_is(1'b1, 8'h1C, 5'd0, 4'd0)},
         '{ps2sc_pkg::OP_RELEASE, 16'h00E0, ps2sc_pkg::SK_NORMAL, 10'd0,   1'b1,
           status_is(1'b1, 8'h1C, 5'd2, 4'd0)},
         '{ps2sc_pkg::OP_RELEASE, 16'h1234, SK_SPARE,             10'd0,   1'b1,
           status_is(1'b1, 8'h1C, 5'd5, 4'd0)},
         '{ps2sc_pkg::OP_RELEASE, 16'hBEEF, ps2sc_pkg::SK_PRTSC,  10'd0,   1'b1,
           status_is(1'b1, 8'h1C, 5'd10, 4'd0)},
         '{ps2sc_pkg::OP_PRESS,   16'hE075, ps2sc_pkg::SK_NORMAL, 10'd0,   1'b1,
           status_is(1'b1, 8'h1C, 5'd12, 4'd0)},
         '{ps2sc_pkg::OP_PRESS,   16'h0000, ps2sc_pkg::SK_PAUSE,  10'd0,   1'b1,
           status_is(1'b1, 8'h1C, 5'd16, 4'd4)},
         '{ps2sc_pkg::OP_RELEASE, 16'hFFFF, ps2sc_pkg::SK_PAUSE,  10'd0,   1'b1,
           status_is(1'b1, 8'h1C, 5'd16, 4'd0)},
         '{ps2sc_pkg::OP_RELEASE, 16'hE175, SK_SPARE,             10'd0,   1'b1,
           status_is(1'b1, 8'h1C, 5'd16, 4'd3)},
         '{ps2sc_pkg::OP_PRESS,   16'hFFFF, ps2sc_pkg::SK_NORMAL, 10'd0,   1'b1,
           status_is(1'b1, 8'h1C, 5'd16, 4'd2)},
         '{ps2sc_pkg::OP_PRESS,   16'h0000, ps2sc_pkg::SK_NORMAL, 10'd0,   1'b1,
           status_is(1'b1, 8'h1C, 5'd16, 4'd1)},
         '{ps2sc_pkg::OP_RELEASE, 16'hE07D, ps2sc_pkg::SK_NORMAL, 10'd0,   1'b1,
           status_is(1'b1, 8'h1C, 5'd16, 4'd3)},
         '{ps2sc_pkg::OP_READ,    16'h0000, ps2sc_pkg::SK_NORMAL, 10'h3FF, 1'b1,
           status_is(1'b1, 8'h1C, 5'd16, 4'd0)},
         '{ps2sc_pkg::OP_TICK,    16'h0000, ps2sc_pkg::SK_NORMAL, 10'h3FF, 1'b0, UNTYPED},
         '{ps2sc_pkg::OP_PRESS,   16'h00FF, ps2sc_pkg::SK_PRTSC,  10'd0,   1'b0, UNTYPED},
         '{ps2sc_pkg::OP_TICK,    16'h0000, ps2sc_pkg::SK_NORMAL, 10'd512, 1'b0, UNTYPED},
         '{ps2sc_pkg::OP_RELEASE, 16'h0000, ps2sc_pkg::SK_NORMAL, 10'd0,   1'b0, UNTYPED}
      };

      // act, gap, random span, items, tick %, sender gap, hold-off, drain, spare write
      plan = '{
         '{24'd0,    24'd0,        0,   250, 45, 6,  1'b0, 1'b0, 1'b0, CSR_SPARE_LO},
         '{24'd1,    24'd1,        0,   200, 50, 0,  1'b1, 1'b0, 1'b1, CSR_SPARE_LO},
         '{24'd0,    24'd0,        800, 300, 55, 10, 1'b0, 1'b1, 1'b0, CSR_SPARE_LO},
         '{24'd1500, 24'd3000,     0,   250, 50, 4,  1'b1, 1'b0, 1'b0, CSR_SPARE_LO},
         '{24'd0,    24'hFFFFFF,   0,   150, 40, 6,  1'b0, 1'b0, 1'b1, CSR_SPARE_HI},
         '{24'd197,  24'd39000,    0,   250, 75, 8,  1'b0, 1'b0, 1'b0, CSR_SPARE_LO},
         '{24'd0,    24'd0,        300, 400, 55, 12, 1'b1, 1'b1, 1'b0, CSR_SPARE_LO}
      };

      // shadow reset state
      fifo_rd      = 0;
      fifo_wr      = 0;
      fifo_fill    = 0;
      link_state   = ps2sc_pkg::PH_IDLE;
      strobe_timer = '0;
      data_latch   = '0;
      pin_out      = 1'b1;
      cfg_active   = ps2sc_pkg::ACTIVE_TIME_RST;
      cfg_gap      = ps2sc_pkg::GAP_TIME_RST;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table at the reset timing
      foreach (stim_rows[i]) begin
         send_request(stim_rows[i].op, stim_rows[i].code, stim_rows[i].sk, stim_rows[i].el,
                      stim_rows[i].typed, stim_rows[i].want);
      end

      // random phases, each with its own strobe timing
      for (p = 0; p < 7; p++) begin
         quiesce();
         act = plan[p].act;
         gp  = plan[p].gp;
         if (plan[p].span != 0) begin
            act = 24'($urandom_range(plan[p].span));
            gp  = 24'($urandom_range(2 * plan[p].span));
         end
         write_csr(ps2sc_pkg::CSR_ACTIVE_TIME, act);
         write_csr(ps2sc_pkg::CSR_GAP_TIME, gp);
         if (plan[p].spare) write_csr(plan[p].spare_idx, 24'($urandom));
         sender_gap_max = plan[p].gap_max;
         for (n = 0; n < plan[p].items; n++) begin
            if (plan[p].hold && n == plan[p].items / 3) holdoff_asks++;
            if (plan[p].drain && n == plan[p].items / 2) quiesce();
            roll = $urandom_range(99);
            if (roll >= 92) op = ps2sc_pkg::OP_READ;
            else if (roll < plan[p].tick_pct) op = ps2sc_pkg::OP_TICK;
            else if ($urandom_range(1) == 0) op = ps2sc_pkg::OP_PRESS;
            else op = ps2sc_pkg::OP_RELEASE;
            case ($urandom_range(7))
               0, 1, 2: code = 16'($urandom_range(255));
               3, 4:    code = {ps2sc_pkg::BYTE_E0, 8'($urandom_range(255))};
               5:       code = {8'($urandom_range(255, 1)), 8'($urandom_range(255))};
               6:       code = 16'($urandom);
               default: code = ($urandom_range(1) != 0) ? {8'h00, ps2sc_pkg::BYTE_E0}
                                                        : {ps2sc_pkg::BYTE_E0,
                                                           ps2sc_pkg::BYTE_E0};
            endcase
            case ($urandom_range(11))
               8:       sk = ps2sc_pkg::SK_PAUSE;
               9:       sk = ps2sc_pkg::SK_PRTSC;
               10:      sk = SK_SPARE;
               default: sk = ps2sc_pkg::SK_NORMAL;
            endcase
            case ($urandom_range(9))
               0:       el = '0;
               1:       el = '1;
               default: el = 10'($urandom_range(1023));
            endcase
            send_request(op, code, sk, el, 1'b0, UNTYPED);
         end
      end

      // empty the queue with zero timing, then hold the active phase at the top threshold
      quiesce();
      write_csr(ps2sc_pkg::CSR_ACTIVE_TIME, '0);
      write_csr(ps2sc_pkg::CSR_GAP_TIME, '0);
      sender_gap_max = 0;
      repeat (60) send_request(ps2sc_pkg::OP_TICK, '0, ps2sc_pkg::SK_NORMAL, '1, 1'b0,
                               UNTYPED);
      quiesce();
      write_csr(ps2sc_pkg::CSR_ACTIVE_TIME, ps2sc_pkg::TIMER_MAX);
      send_request(ps2sc_pkg::OP_PRESS, 16'h005A, ps2sc_pkg::SK_NORMAL, '0, 1'b0, UNTYPED);
      for (n = 0; n < SOAK_TICKS; n++) begin
         op = (n % 10 == 9) ? ps2sc_pkg::OP_READ : ps2sc_pkg::OP_TICK;
         send_request(op, '0, ps2sc_pkg::SK_NORMAL, '1, 1'b0, UNTYPED);
      end

      quiesce();
      if (fault_count == 0) begin
         $display("ps2_scan_code_queue_and_strobe_unit_tb: clean");
      end else begin
         $display("ps2_scan_code_queue_and_strobe_unit_tb: errors");
      end
      $finish;
   end

endmodule

// ----- ps2_scan_code_queue_and_strobe_unit.f -----
rtl/ps2sc_pkg.sv
rtl/ps2_scan_code_queue_and_strobe_unit.sv
bench/ps2_scan_code_queue_and_strobe_unit_tb.sv
